FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, a, c)
`define ASSERT_NEXT(label, a, c)
`endif
`endif

FILE: hdl/wvhe_pkg.sv
`default_nettype none
package wvhe_pkg;
  localparam int RingDepth = 64;
  localparam int SlotW = $clog2(RingDepth);
  localparam int CntW = SlotW + 1;
  localparam int CordicSteps = 18;
  localparam int AngW = 20;
  localparam int CordW = 36;
  localparam int HalfTurn = 524288;
  localparam int DivW = 56;
  localparam logic [19:0] MegaScale = 20'd1000000;
  localparam logic [2:0] AddrWindow = 3'd0;
  localparam logic KindPose = 1'b0;
  localparam logic KindRef = 1'b1;

  function automatic logic [AngW-1:0] atan_lut(input logic [4:0] i);
    logic [AngW-1:0] v;
    case (i)
      5'd0: v = 20'd131072;
      5'd1: v = 20'd77376;
      5'd2: v = 20'd40884;
      5'd3: v = 20'd20753;
      5'd4: v = 20'd10417;
      5'd5: v = 20'd5213;
      5'd6: v = 20'd2607;
      5'd7: v = 20'd1304;
      5'd8: v = 20'd652;
      5'd9: v = 20'd326;
      5'd10: v = 20'd163;
      5'd11: v = 20'd81;
      5'd12: v = 20'd41;
      5'd13: v = 20'd20;
      5'd14: v = 20'd10;
      5'd15: v = 20'd5;
      5'd16: v = 20'd3;
      5'd17: v = 20'd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

FILE: hdl/wvhe_rate_div.sv
`default_nettype none
// Serial scaled rate: |d|*1e6 by shift-add (one multiplier bit a cycle),
// then restoring division (one quotient bit a cycle), round and saturate.
module wvhe_rate_div import wvhe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic signed [32:0] d,
  input  wire logic [39:0]       dt,
  output logic                   done,
  output logic [31:0]            rate
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MUL = 4'b0010, S_DIV = 4'b0100, S_FIN = 4'b1000
  } st_t;
  st_t st_r;
  logic [5:0] cnt_r;
  logic neg_r;
  logic [DivW-1:0] acc_r;
  logic [DivW-1:0] mcand_r;
  logic [19:0] mplier_r;
  logic [DivW:0] rem_r;
  logic [DivW-1:0] quo_r;
  logic [40:0] den_r;
  logic [32:0] mag;
  logic [DivW:0] trial;
  logic [DivW:0] sub;
  logic [DivW-1:0] q;

  assign mag = d[32] ? 33'(-d) : 33'(d);
  // dividend is 2*mag*1e6 + dt; quotient is its floor over 2*dt
  assign trial = {rem_r[DivW-1:0], quo_r[DivW-1]};
  assign sub = trial - (DivW+1)'(den_r);
  assign q = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st_r)
        S_IDLE: if (start) begin
          st_r <= S_MUL;
          cnt_r <= '0;
          neg_r <= d[32];
          acc_r <= '0;
          mcand_r <= DivW'(mag);
          mplier_r <= MegaScale;
          den_r <= {dt, 1'b0};
        end
        S_MUL: begin
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd19) begin
            st_r <= S_DIV;
            cnt_r <= '0;
          end
        end
        S_DIV: begin
          if (cnt_r == 6'd0) begin
            quo_r <= {acc_r[DivW-2:0], 1'b0} + DivW'(den_r[40:1]);
            rem_r <= '0;
            cnt_r <= 6'd1;
          end else begin
            if (!sub[DivW]) rem_r <= sub;
            else rem_r <= trial;
            quo_r <= {quo_r[DivW-2:0], ~sub[DivW]};
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r == 6'(DivW)) st_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (neg_r) rate <= (q > DivW'(32'h80000000)) ? 32'h80000000 : 32'(-q[31:0]);
          else rate <= (q > DivW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
          done <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/wvhe_cordic.sv
`default_nettype none
// Vectoring CORDIC, one micro rotation a cycle.
module wvhe_cordic import wvhe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic signed [31:0] x_in,
  input  wire logic signed [31:0] y_in,
  output logic                   done,
  output logic [AngW-1:0]        angle
);
  logic busy_r;
  logic [4:0] step_r;
  logic signed [CordW-1:0] x_r, y_r;
  logic [AngW-1:0] z_r;
  logic signed [CordW-1:0] xs, ys;

  assign xs = x_r >>> step_r;
  assign ys = y_r >>> step_r;
  assign angle = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step_r <= '0;
        if (x_in == 0 && y_in == 0) begin
          z_r <= '0;
          done <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          if (x_in < 0) begin
            x_r <= -CordW'(x_in);
            y_r <= -CordW'(y_in);
            z_r <= AngW'(HalfTurn);
          end else begin
            x_r <= CordW'(x_in);
            y_r <= CordW'(y_in);
            z_r <= '0;
          end
        end
      end else if (busy_r) begin
        if (!y_r[CordW-1]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_lut(step_r);
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_lut(step_r);
        end
        step_r <= step_r + 5'd1;
        if (step_r == 5'(CordicSteps - 1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/windowed_velocity_and_heading_error.sv
`default_nettype none
// Windowed velocity and heading error.
// Input channel (in_valid/in_ready): kind 0 is a timestamped position sample,
// kind 1 a reference velocity. One item is worked at a time; in_ready is high
// only while the block is idle.
// A position sample walks the ring from its oldest entry, reading (S_RD) and
// checking (S_CHK) each entry it evicts (up to 64), then, unless the span is
// zero, runs two serial rate units side by side (shift-add multiply, restoring
// divide, then round and saturate) and waits until both are done.
// A reference sample runs two 18-step CORDIC passes in turn.
// Late or repeated position samples are dropped with no result.
// Result channel (out_valid/out_ready): the result is held in an output
// register until transferred while the next item is worked; a finished result
// waits for that register, and the block waits with it.
// Configuration: APB write to address 0 sets window_us (reset 500000).
// Reset (synchronous, rst_n low) empties the ring and clears the held
// velocity; ring contents need no clearing since only written slots are read.
module windowed_velocity_and_heading_error import wvhe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_kind,
  input  wire logic [39:0]       in_time_us,
  input  wire logic signed [31:0] in_sample_x,
  input  wire logic signed [31:0] in_sample_y,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_result_kind,
  output logic signed [31:0]     out_vel_x,
  output logic signed [31:0]     out_vel_y,
  output logic signed [15:0]     out_heading_error,
  output logic                   out_window_truncated,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
`include "assert_macros.svh"
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_RD = 9'b000000010, S_CHK = 9'b000000100,
    S_WR = 9'b000001000, S_RD2 = 9'b000010000, S_DIV = 9'b000100000,
    S_CRD = 9'b001000000, S_CRD2 = 9'b010000000, S_OUT = 9'b100000000
  } st_t;
  st_t st_r;

  logic [23:0] window_r;
  logic [SlotW-1:0] newest_r;
  logic [CntW-1:0] count_r;
  logic [39:0] last_r;
  logic started_r;
  logic [31:0] hvx_r, hvy_r;
  logic [39:0] t_r;
  logic signed [31:0] sx_r, sy_r;
  logic trunc_r;
  logic kind_r;
  logic [39:0] mem_t [RingDepth];
  logic [31:0] mem_x [RingDepth];
  logic [31:0] mem_y [RingDepth];
  logic [39:0] rd_t;
  logic [31:0] rd_x, rd_y;
  logic [SlotW-1:0] rd_addr;
  logic [SlotW-1:0] oldest;
  logic mem_we;
  logic [SlotW-1:0] wr_slot;
  logic [39:0] age;

  logic div_start, dx_done, dy_done, dxd_r, dyd_r;
  logic [31:0] rx, ry;
  logic c_start, c_done;
  logic signed [31:0] c_x, c_y;
  logic [AngW-1:0] c_ang, ang_ref_r;
  logic [AngW-1:0] adiff;
  logic c_go_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == AddrWindow) ? {8'd0, window_r} : 32'd0;
  assign in_ready = (st_r == S_IDLE);
  assign oldest = SlotW'(newest_r + SlotW'(1) - SlotW'(count_r));
  assign wr_slot = newest_r + SlotW'(1);
  assign mem_we = (st_r == S_WR);
  assign age = t_r - rd_t;
  assign rd_addr = oldest;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_t[wr_slot] <= t_r;
      mem_x[wr_slot] <= sx_r;
      mem_y[wr_slot] <= sy_r;
    end
    rd_t <= mem_t[rd_addr];
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  wvhe_rate_div u_divx (.clk, .rst_n, .start(div_start),
    .d(33'(sx_r) - 33'($signed(rd_x))), .dt(age), .done(dx_done), .rate(rx));
  wvhe_rate_div u_divy (.clk, .rst_n, .start(div_start),
    .d(33'(sy_r) - 33'($signed(rd_y))), .dt(age), .done(dy_done), .rate(ry));
  wvhe_cordic u_cordic (.clk, .rst_n, .start(c_start), .x_in(c_x), .y_in(c_y),
    .done(c_done), .angle(c_ang));

  assign c_x = (st_r == S_CRD) ? sx_r : $signed(hvx_r);
  assign c_y = (st_r == S_CRD) ? sy_r : $signed(hvy_r);
  assign adiff = ang_ref_r - c_ang + AngW'(8);

  assign c_start = c_go_r && (st_r == S_CRD || st_r == S_CRD2);
  assign div_start = (st_r == S_RD2) && !c_go_r && (age != 40'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      window_r <= 24'd500000;
      newest_r <= '0;
      count_r <= '0;
      last_r <= '0;
      started_r <= 1'b0;
      hvx_r <= '0;
      hvy_r <= '0;
      out_valid <= 1'b0;
      c_go_r <= 1'b0;
      dxd_r <= 1'b0;
      dyd_r <= 1'b0;
    end else begin
      c_go_r <= 1'b0;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == AddrWindow)
        window_r <= cfg_pwdata[23:0];
      if (out_valid && out_ready && st_r != S_OUT) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_valid && in_ready) begin
          kind_r <= in_kind;
          t_r <= in_time_us;
          sx_r <= in_sample_x;
          sy_r <= in_sample_y;
          trunc_r <= 1'b0;
          if (in_kind == KindRef) begin
            st_r <= S_CRD;
            c_go_r <= 1'b1;
          end else if (!started_r || in_time_us > last_r) begin
            started_r <= 1'b1;
            last_r <= in_time_us;
            st_r <= S_RD;
          end
        end
        S_RD: st_r <= S_CHK;  // read latency of the ring
        S_CHK: begin
          // drop the oldest entry while it lies outside the window
          if (count_r != '0 && age > 40'(window_r)) begin
            count_r <= count_r - CntW'(1);
            st_r <= S_RD;
          end else begin
            if (count_r == CntW'(RingDepth)) begin
              count_r <= CntW'(RingDepth - 1);
              trunc_r <= 1'b1;
            end
            st_r <= S_WR;
          end
        end
        S_WR: begin
          newest_r <= wr_slot;
          count_r <= count_r + CntW'(1);
          st_r <= S_RD2;
          c_go_r <= 1'b1;
        end
        S_RD2: if (!c_go_r) begin
          // wait until c_go_r clears, so that the oldest entry read is ready
          if (age == 40'd0) st_r <= S_OUT;
          else begin
            st_r <= S_DIV;
            dxd_r <= 1'b0;
            dyd_r <= 1'b0;
          end
        end
        S_DIV: begin
          if (dx_done) begin hvx_r <= rx; dxd_r <= 1'b1; end
          if (dy_done) begin hvy_r <= ry; dyd_r <= 1'b1; end
          if ((dxd_r || dx_done) && (dyd_r || dy_done)) st_r <= S_OUT;
        end
        S_CRD: if (c_done) begin
          ang_ref_r <= c_ang;
          st_r <= S_CRD2;
          c_go_r <= 1'b1;
        end
        S_CRD2: if (c_done) st_r <= S_OUT;
        S_OUT: if (!out_valid || out_ready) begin
          // load once the output register is free or leaving this cycle
          out_valid <= 1'b1;
          out_result_kind <= kind_r;
          out_heading_error <= (kind_r == KindRef) ? adiff[19:4] : 16'd0;
          out_vel_x <= hvx_r;
          out_vel_y <= hvy_r;
          out_window_truncated <= trunc_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_ready_idle, in_ready, st_r == S_IDLE)
  `ASSERT_IMPLIES(a_count_max, 1'b1, count_r <= CntW'(RingDepth))
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wvhe_pkg::*;

  localparam int DEPTH = 64;
  localparam logic KIND_POSE = 1'b0;
  localparam logic KIND_REF = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [39:0] t;
    logic [31:0] x;
    logic [31:0] y;
  } sample_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [15:0] hdg;
    logic        trunc;
  } estimate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [39:0] in_time_us = '0;
  logic signed [31:0] in_sample_x = '0;
  logic signed [31:0] in_sample_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_result_kind;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic signed [15:0] out_heading_error;
  logic out_window_truncated;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  always #2 clk = ~clk;

  windowed_velocity_and_heading_error u_top (.*);

  // predictor state
  logic [39:0] win_time [DEPTH];
  logic [31:0] win_x [DEPTH];
  logic [31:0] win_y [DEPTH];
  int unsigned head_slot;
  int unsigned fill;
  logic [39:0] last_time;
  bit seen_pose;
  logic [31:0] vel_hold_x;
  logic [31:0] vel_hold_y;
  logic [23:0] window_len;

  sample_t pending_q[$];
  estimate_t estimate_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int phase = 0;
  bit hold_done = 0;
  bit stim_done = 0;
  logic took = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [19:0] atan_step(int i);
    logic [19:0] tbl [18] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                              652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    return tbl[i];
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z, xs, ys;
    logic [19:0] step;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HalfTurn;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      step = atan_step(i);
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z += step;
      end else begin
        x = x - ys;
        y = y + xs;
        z -= step;
      end
    end
    return z;
  endfunction

  function automatic logic [31:0] rate_per_sec(longint d, longint unsigned dt);
    longint unsigned mag, q;
    mag = longint'(d < 0 ? -d : d) * 64'd1000000;
    q = (2 * mag + dt) / (2 * dt);
    if (d < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'd0 - q[31:0];
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic int unsigned tail_slot();
    return (head_slot + DEPTH + 1 - fill) % DEPTH;
  endfunction

  task automatic predict(input sample_t s);
    estimate_t e;
    int unsigned old;
    logic [39:0] dt;
    longint diff;
    e = '0;
    e.kind = s.kind;
    if (s.kind == KIND_POSE) begin
      if (seen_pose && s.t <= last_time) return;
      seen_pose = 1;
      last_time = s.t;
      while (fill > 0 && (s.t - win_time[tail_slot()]) > {16'd0, window_len}) fill--;
      if (fill >= DEPTH) begin
        fill = DEPTH - 1;
        e.trunc = 1'b1;
      end
      head_slot = (head_slot + 1) % DEPTH;
      win_time[head_slot] = s.t;
      win_x[head_slot] = s.x;
      win_y[head_slot] = s.y;
      fill++;
      old = tail_slot();
      dt = s.t - win_time[old];
      if (dt != 0) begin
        vel_hold_x = rate_per_sec(longint'($signed(s.x)) - longint'($signed(win_x[old])),
                                  dt);
        vel_hold_y = rate_per_sec(longint'($signed(s.y)) - longint'($signed(win_y[old])),
                                  dt);
      end
    end else begin
      diff = cordic_angle($signed(s.x), $signed(s.y))
           - cordic_angle($signed(vel_hold_x), $signed(vel_hold_y));
      diff = floor_shr(diff + 8, 4);
      e.hdg = diff[15:0];
    end
    e.vx = vel_hold_x;
    e.vy = vel_hold_y;
    estimate_q.push_back(e);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("error: %s got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // record each input transfer at the edge where it happens
  always @(posedge clk) took <= in_valid && in_ready;

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (took) begin
        predict(pending_q[0]);
        void'(pending_q.pop_front());
      end
      if (!in_valid || took) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          {in_kind, in_time_us, in_sample_x, in_sample_y} <= pending_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= (hold_off == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, started once when the stalling phase begins
  always @(posedge clk) begin
    if (phase == 3 && !hold_done) begin
      hold_off <= 2000;
      hold_done <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    estimate_t e;
    if (rst_n && out_valid && out_ready) begin
      if (estimate_q.size() == 0) begin
        report("unexpected result", out_vel_x, 0);
      end else begin
        e = estimate_q.pop_front();
        if (out_result_kind !== e.kind) report("result_kind", out_result_kind, e.kind);
        if (out_vel_x !== e.vx) report("vel_x", out_vel_x, e.vx);
        if (out_vel_y !== e.vy) report("vel_y", out_vel_y, e.vy);
        if (out_heading_error !== e.hdg) report("heading_error", out_heading_error, e.hdg);
        if (out_window_truncated !== e.trunc)
          report("window_truncated", out_window_truncated, e.trunc);
      end
    end
  end

  task automatic cfg_write(input logic [23:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= AddrWindow;
    cfg_pwdata <= {8'd0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    window_len = val;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || estimate_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  logic [39:0] clock_us;

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(2000) - 1000;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic queue_random(input int n, input int max_step);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      s.x = rand_pos();
      s.y = rand_pos();
      if ($urandom_range(99) < 25) begin
        s.kind = KIND_REF;
        s.t = {$urandom(), 8'($urandom())};
      end else begin
        s.kind = KIND_POSE;
        case ($urandom_range(19))
          0: s.t = clock_us - 40'($urandom_range(3));
          1: begin
            // jump by up to 20000000 us, which can pass even the widest window
            clock_us = clock_us + 40'($urandom_range(20_000_000));
            s.t = clock_us;
          end
          default: begin
            clock_us = clock_us + 40'($urandom_range(max_step));
            s.t = clock_us;
          end
        endcase
      end
      pending_q.push_back(s);
    end
  endtask

  initial begin
    head_slot = 0;
    fill = 0;
    last_time = '0;
    seen_pose = 0;
    vel_hold_x = '0;
    vel_hold_y = '0;
    window_len = 24'd500000;
    clock_us = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reference before any pose, origin, extremes, repeats, half turn
    pending_q.push_back({KIND_REF, 40'd0, 32'd0, 32'd0});
    pending_q.push_back({KIND_REF, 40'd5, 32'h0001_0000, 32'd0});
    pending_q.push_back({KIND_POSE, 40'd0, 32'h8000_0000, 32'h7FFF_FFFF});
    pending_q.push_back({KIND_POSE, 40'd0, 32'd0, 32'd0});
    pending_q.push_back({KIND_POSE, 40'd1, 32'h7FFF_FFFF, 32'h8000_0000});
    pending_q.push_back({KIND_REF, 40'd0, 32'h7FFF_FFFF, 32'h8000_0000});
    pending_q.push_back({KIND_REF, 40'd0, 32'h8000_0000, 32'h7FFF_FFFF});
    pending_q.push_back({KIND_POSE, 40'd3, 32'h0001_0000, 32'h0000_0000});
    pending_q.push_back({KIND_REF, 40'd0, 32'hFFFF_0000, 32'h0000_0000});
    pending_q.push_back({KIND_POSE, 40'd3, 32'd5, 32'd5});
    pending_q.push_back({KIND_POSE, 40'd2, 32'd5, 32'd5});
    drain();

    // default window, no idling
    clock_us = 40'd10;
    phase = 1;
    queue_random(400, 20000);
    drain();

    // wide window, idle sender: the ring fills and truncates
    cfg_write(24'd10_000_000);
    send_idle_pct = 66;
    phase = 2;
    queue_random(300, 100000);
    drain();

    // one microsecond window, stalling receiver with a long hold-off first
    cfg_write(24'd1);
    send_idle_pct = 0;
    recv_stall_pct = 66;
    phase = 3;
    queue_random(300, 2);
    drain();

    // zero window keeps only the newest sample, then the widest window
    cfg_write(24'd0);
    send_idle_pct = 23;
    recv_stall_pct = 23;
    phase = 4;
    queue_random(100, 1000);
    drain();
    cfg_write(24'hFF_FFFF);
    queue_random(330, 400000);
    drain();

    // large step, then the last representable timestamp and a repeat of it
    pending_q.push_back({KIND_POSE, clock_us + 40'd1_000_000, 32'd7, 32'hFFFF_FFF9});
    pending_q.push_back({KIND_POSE, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h1});
    pending_q.push_back({KIND_REF, 40'hFF_FFFF_FFFF, 32'd0, 32'hFFFF_FFFF});
    pending_q.push_back({KIND_POSE, 40'hFF_FFFF_FFFF, 32'd3, 32'd3});
    drain();
    stim_done = 1;
  end

  initial begin
    #20ms;
    $display("windowed_velocity_and_heading_error: mismatch");
    $finish;
  end

  initial begin
    wait (stim_done);
    repeat (300) @(posedge clk);
    if (errors == 0 && estimate_q.size() == 0) begin
      $display("windowed_velocity_and_heading_error: match");
    end else begin
      $display("windowed_velocity_and_heading_error: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+hdl
hdl/wvhe_pkg.sv
hdl/wvhe_rate_div.sv
hdl/wvhe_cordic.sv
hdl/windowed_velocity_and_heading_error.sv
test/tb.sv
